FILE: hdl/qmmd_pkg.sv
// Package for the quad motor mixer with desaturation.
// Holds field widths, register reset values, CSR register indexes and the
// constants of the divide-by-100 reciprocal. No dependencies.
`timescale 1ns / 1ps

package qmmd_pkg;

   // Field widths
   localparam int PWM_W  = 16;
   localparam int THR_W  = 7;
   localparam int TILT_W = 16;

   // Motor lanes
   localparam int LANES     = 4;
   localparam int MOT_X_POS = 0;
   localparam int MOT_X_NEG = 1;
   localparam int MOT_Y_POS = 2;
   localparam int MOT_Y_NEG = 3;

   // throttle (7b unsigned) times span (17b signed)
   localparam int PROD_W = 24;
   // signed mix arithmetic: motors, headroom, shift, all well inside +/-2^19
   localparam int MIX_W  = 20;

   // Floor divide by 100: bias the signed product positive, then
   // floor(n/100) = floor(floor(n/4)/25), done by reciprocal multiply.
   localparam int DIV_BIAS_Q  = 131072;              // 2^17, removed after the divide
   localparam int DIV_BIAS    = 100 * DIV_BIAS_Q;
   localparam int DIVN_W      = 25;                  // biased numerator width
   localparam int QTR_W       = DIVN_W - 2;          // numerator after the divide by 4
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SHIFT) / 25 + 1);
   localparam int RPROD_W     = QTR_W + RECIP_W;
   localparam int QUO_W       = 18;

   // CSR port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      CSR_PWM_MAX  = 2'd0,
      CSR_PWM_MIN  = 2'd1,
      CSR_PWM_IDLE = 2'd2
   } csr_index_type;

   localparam logic [PWM_W-1:0] PWM_MAX_RST  = 16'd2000;
   localparam logic [PWM_W-1:0] PWM_MIN_RST  = 16'd1100;
   localparam logic [PWM_W-1:0] PWM_IDLE_RST = 16'd1000;

   typedef logic signed [MIX_W-1:0] mix_type;

endpackage

FILE: hdl/quad_motor_mixer_desaturate_top.sv
// Quad motor mixer with desaturation: four-stage pipeline, CSR block and checks.
// Depends on qmmd_pkg.
`timescale 1ns / 1ps

// Each accepted beat updates either the throttle percentage (kind 0) or the
// x/y tilt pair (kind 1) and yields one beat of four motor commands. A new
// beat is taken every cycle unless req_stall is high. The four register
// stages are the throttle product, the divide by 100 (reciprocal multiply),
// the mix with headroom search, and the common shift with clamp. A stall on
// the result side backs up through the stages, and empty stages close up,
// so stall on the request side rises only when all four stages hold data.
// The three PWM registers sit at byte addresses 0 (max), 4 (min) and
// 8 (idle) and are to be written only while no beat is in flight.
module quad_motor_mixer_desaturate_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [qmmd_pkg::THR_W-1:0]          req_throttle_percent,
   input  logic signed [qmmd_pkg::TILT_W-1:0]  req_tilt_x,
   input  logic signed [qmmd_pkg::TILT_W-1:0]  req_tilt_y,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [qmmd_pkg::PWM_W-1:0]          rsp_motor_x_pos,
   output logic [qmmd_pkg::PWM_W-1:0]          rsp_motor_x_neg,
   output logic [qmmd_pkg::PWM_W-1:0]          rsp_motor_y_pos,
   output logic [qmmd_pkg::PWM_W-1:0]          rsp_motor_y_neg,
   // CSR port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [qmmd_pkg::CSR_AW-1:0]         paddr,
   input  logic [qmmd_pkg::CSR_DW-1:0]         pwdata,
   output logic [qmmd_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);
   import qmmd_pkg::*;

   // ---------------------------------------------------------------- CSRs
   logic [PWM_W-1:0] pwm_max_ff, pwm_min_ff, pwm_idle_ff;
   logic             csr_write;
   csr_index_type    csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_sel   = csr_index_type'(paddr[CSR_AW-1:2]);

   // Write the addressed register; unknown addresses are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_max_ff  <= PWM_MAX_RST;
         pwm_min_ff  <= PWM_MIN_RST;
         pwm_idle_ff <= PWM_IDLE_RST;
      end else if (csr_write) begin
         case (csr_sel)
            CSR_PWM_MAX:  pwm_max_ff  <= pwdata[PWM_W-1:0];
            CSR_PWM_MIN:  pwm_min_ff  <= pwdata[PWM_W-1:0];
            CSR_PWM_IDLE: pwm_idle_ff <= pwdata[PWM_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (csr_sel)
         CSR_PWM_MAX:  prdata = CSR_DW'(pwm_max_ff);
         CSR_PWM_MIN:  prdata = CSR_DW'(pwm_min_ff);
         CSR_PWM_IDLE: prdata = CSR_DW'(pwm_idle_ff);
         default:      prdata = '0;
      endcase
   end

   // Config values as signed mix operands
   mix_type hi_s, lo_lim_s, idle_s;
   assign hi_s     = mix_type'({1'b0, pwm_max_ff});
   assign lo_lim_s = mix_type'({1'b0, pwm_min_ff});
   assign idle_s   = mix_type'({1'b0, pwm_idle_ff});

   // ------------------------------------------------------- flow control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic ready1, ready2, ready3, ready4;
   logic accept;

   assign ready4    = !rsp_valid_ff || !rsp_stall;
   assign ready3    = !s3_valid_ff || ready4;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1;
   assign accept    = req_valid && ready1;

   // ------------------------------------ stage 1: state update, product
   logic [THR_W-1:0]         throttle_ff, throttle_in;
   logic signed [TILT_W-1:0] tilt_x_ff, tilt_x_in, tilt_y_ff, tilt_y_in;
   logic signed [PWM_W:0]    span;
   logic signed [PROD_W-1:0] prod_in, s1_prod_ff;
   logic                     s1_idle_ff;
   logic signed [TILT_W-1:0] s1_tilt_x_ff, s1_tilt_y_ff;

   assign throttle_in = req_kind ? throttle_ff : req_throttle_percent;
   assign tilt_x_in   = req_kind ? req_tilt_x : tilt_x_ff;
   assign tilt_y_in   = req_kind ? req_tilt_y : tilt_y_ff;
   assign span        = $signed({1'b0, pwm_max_ff}) - $signed({1'b0, pwm_idle_ff});
   assign prod_in     = PROD_W'($signed({1'b0, throttle_in})) * PROD_W'(span);

   // Hold the mixer state across beats
   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_ff <= '0;
         tilt_x_ff   <= '0;
         tilt_y_ff   <= '0;
      end else if (accept) begin
         throttle_ff <= throttle_in;
         tilt_x_ff   <= tilt_x_in;
         tilt_y_ff   <= tilt_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ready1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_prod_ff   <= prod_in;
         s1_idle_ff   <= (throttle_in == '0);
         s1_tilt_x_ff <= tilt_x_in;
         s1_tilt_y_ff <= tilt_y_in;
      end
   end

   // ------------------------------------- stage 2: floor divide, base
   logic [DIVN_W-1:0]        div_num;
   logic [QTR_W-1:0]         div_qtr;
   logic [RPROD_W-1:0]       recip_prod;
   logic [QUO_W-1:0]         quotient;
   mix_type                  base_in, s2_base_ff;
   logic                     s2_idle_ff;
   logic signed [TILT_W-1:0] s2_tilt_x_ff, s2_tilt_y_ff;

   // Bias positive so the truncating reciprocal gives the floor
   assign div_num    = DIVN_W'(DIVN_W'(s1_prod_ff) + DIVN_W'(DIV_BIAS));
   assign div_qtr    = div_num[DIVN_W-1:2];
   assign recip_prod = RPROD_W'(div_qtr) * RPROD_W'(RECIP_M);
   assign quotient   = recip_prod[RECIP_SHIFT +: QUO_W];
   assign base_in    = idle_s + mix_type'(quotient) - mix_type'(DIV_BIAS_Q);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         s2_base_ff   <= base_in;
         s2_idle_ff   <= s1_idle_ff;
         s2_tilt_x_ff <= s1_tilt_x_ff;
         s2_tilt_y_ff <= s1_tilt_y_ff;
      end
   end

   // ------------------------------------- stage 3: mix and headroom
   mix_type mot_in [LANES];
   mix_type s3_mot_ff [LANES];
   mix_type up_in, lo_in, s3_up_ff, s3_lo_ff;
   logic    s3_idle_ff;

   always_comb begin
      mot_in[MOT_X_POS] = s2_base_ff + mix_type'(s2_tilt_x_ff);
      mot_in[MOT_X_NEG] = s2_base_ff - mix_type'(s2_tilt_x_ff);
      mot_in[MOT_Y_POS] = s2_base_ff + mix_type'(s2_tilt_y_ff);
      mot_in[MOT_Y_NEG] = s2_base_ff - mix_type'(s2_tilt_y_ff);
   end

   // Smallest room above and below across the four motors
   always_comb begin
      up_in = hi_s - lo_lim_s;
      lo_in = hi_s - lo_lim_s;
      for (int i = 0; i < LANES; i++) begin
         if (hi_s - mot_in[i] < up_in) begin
            up_in = hi_s - mot_in[i];
         end
         if (mot_in[i] - lo_lim_s < lo_in) begin
            lo_in = mot_in[i] - lo_lim_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ready3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         s3_mot_ff  <= mot_in;
         s3_up_ff   <= up_in;
         s3_lo_ff   <= lo_in;
         s3_idle_ff <= s2_idle_ff;
      end
   end

   // ------------------------------------ stage 4: shift and clamp
   mix_type          diff, half, shift;
   mix_type          lane_v [LANES];
   logic [PWM_W-1:0] mot_out_in [LANES];
   logic [PWM_W-1:0] rsp_mot_ff [LANES];
   logic             out_idle_ff;

   // Half the imbalance, truncated toward zero
   assign diff = s3_up_ff - s3_lo_ff;
   assign half = (diff + mix_type'(diff[MIX_W-1])) >>> 1;

   // Recentre only when a motor leaves the window, bounded by the deficit
   always_comb begin
      shift = half;
      if (s3_up_ff < 0 && shift < s3_up_ff) begin
         shift = s3_up_ff;
      end
      if (s3_lo_ff < 0 && shift > -s3_lo_ff) begin
         shift = -s3_lo_ff;
      end
      if (!(s3_up_ff < 0 || s3_lo_ff < 0)) begin
         shift = '0;
      end
   end

   // Apply lower bound then upper bound; idle output at zero throttle
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_v[i] = s3_mot_ff[i] + shift;
         if (lane_v[i] < lo_lim_s) begin
            lane_v[i] = lo_lim_s;
         end
         if (lane_v[i] > hi_s) begin
            lane_v[i] = hi_s;
         end
         mot_out_in[i] = s3_idle_ff ? pwm_idle_ff : lane_v[i][PWM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready4) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         rsp_mot_ff  <= mot_out_in;
         out_idle_ff <= s3_idle_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_motor_x_pos = rsp_mot_ff[MOT_X_POS];
   assign rsp_motor_x_neg = rsp_mot_ff[MOT_X_NEG];
   assign rsp_motor_y_pos = rsp_mot_ff[MOT_Y_POS];
   assign rsp_motor_y_neg = rsp_mot_ff[MOT_Y_NEG];

   // ------------------------------------------------------- assertions
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted beat did not enter stage 1");

   a_throttle_stored: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_kind) |=> (throttle_ff == $past(req_throttle_percent)))
      else $error("throttle state not updated by throttle beat");

   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !ready4) |=> s3_valid_ff)
      else $error("stage 3 beat dropped under stall");

   a_clamp_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_idle_ff) |->
         (rsp_mot_ff[MOT_X_POS] <= pwm_max_ff && rsp_mot_ff[MOT_X_NEG] <= pwm_max_ff &&
          rsp_mot_ff[MOT_Y_POS] <= pwm_max_ff && rsp_mot_ff[MOT_Y_NEG] <= pwm_max_ff))
      else $error("motor command above pwm_max");

endmodule

FILE: tb/quad_motor_mixer_desaturate_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quad_motor_mixer_desaturate_top: throttle and tilt beats
// against a built-in mixer model, PWM register writes and read-back over the CSR port.
// Depends on qmmd_pkg and the mixer RTL.

module quad_motor_mixer_desaturate_top_tb;
   import qmmd_pkg::*;

   // byte address with no register behind it (index 3)
   localparam logic [CSR_AW-1:0] UNMAPPED_ADDR = 4'hC;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PIPE_SETTLE   = 8;
   localparam int CHUNK_BEATS   = 100;
   localparam int HOLD_CYCLES   = 150;

   typedef struct packed {
      logic [PWM_W-1:0] x_pos;
      logic [PWM_W-1:0] x_neg;
      logic [PWM_W-1:0] y_pos;
      logic [PWM_W-1:0] y_neg;
   } motor_cmd_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_kind = 1'b0;
   logic [THR_W-1:0]          req_throttle_percent = '0;
   logic signed [TILT_W-1:0]  req_tilt_x = '0;
   logic signed [TILT_W-1:0]  req_tilt_y = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [PWM_W-1:0]          rsp_motor_x_pos;
   logic [PWM_W-1:0]          rsp_motor_x_neg;
   logic [PWM_W-1:0]          rsp_motor_y_pos;
   logic [PWM_W-1:0]          rsp_motor_y_neg;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_AW-1:0]         paddr = '0;
   logic [CSR_DW-1:0]         pwdata = '0;
   logic [CSR_DW-1:0]         prdata;
   logic                      pready;

   // mixer model state and register copies
   logic [PWM_W-1:0]          pwm_max_now = PWM_MAX_RST;
   logic [PWM_W-1:0]          pwm_min_now = PWM_MIN_RST;
   logic [PWM_W-1:0]          pwm_idle_now = PWM_IDLE_RST;
   logic [THR_W-1:0]          throttle_held = '0;
   logic signed [TILT_W-1:0]  tilt_x_held = '0;
   logic signed [TILT_W-1:0]  tilt_y_held = '0;

   motor_cmd_type motor_queue[$];

   int err_count = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int settings_count = 0;
   int input_stall_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   quad_motor_mixer_desaturate_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_throttle_percent (req_throttle_percent),
      .req_tilt_x           (req_tilt_x),
      .req_tilt_y           (req_tilt_y),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_motor_x_pos      (rsp_motor_x_pos),
      .rsp_motor_x_neg      (rsp_motor_x_neg),
      .rsp_motor_y_pos      (rsp_motor_y_pos),
      .rsp_motor_y_neg      (rsp_motor_y_neg),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Update the held throttle or tilts, then mix, desaturate and clamp.
   function automatic motor_cmd_type mix_beat(input logic kind,
                                              input logic [THR_W-1:0] thr,
                                              input logic signed [TILT_W-1:0] tx,
                                              input logic signed [TILT_W-1:0] ty);
      motor_cmd_type cmd;
      int hi, lo_lim, idle, prod, base, up, dn, shift, v;
      int m[LANES];
      logic [PWM_W-1:0] lane[LANES];
      if (kind == 1'b0)
         throttle_held = thr;
      else begin
         tilt_x_held = tx;
         tilt_y_held = ty;
      end
      // zero throttle parks every motor at idle, whatever the limits
      if (throttle_held == '0) begin
         cmd.x_pos = pwm_idle_now;
         cmd.x_neg = pwm_idle_now;
         cmd.y_pos = pwm_idle_now;
         cmd.y_neg = pwm_idle_now;
         return cmd;
      end
      hi     = int'(pwm_max_now);
      lo_lim = int'(pwm_min_now);
      idle   = int'(pwm_idle_now);
      // floor division: the span goes negative when max sits below idle
      prod = int'(throttle_held) * (hi - idle);
      base = prod / 100;
      if ((prod % 100) != 0 && prod < 0)
         base = base - 1;
      base = base + idle;
      m[MOT_X_POS] = base + int'(tilt_x_held);
      m[MOT_X_NEG] = base - int'(tilt_x_held);
      m[MOT_Y_POS] = base + int'(tilt_y_held);
      m[MOT_Y_NEG] = base - int'(tilt_y_held);
      // headroom above and below, over all four lanes
      up = hi - lo_lim;
      dn = up;
      for (int i = 0; i < LANES; i++) begin
         if (hi - m[i] < up)
            up = hi - m[i];
         if (m[i] - lo_lim < dn)
            dn = m[i] - lo_lim;
      end
      // recentre all lanes together; halving truncates toward zero
      if (up < 0 || dn < 0) begin
         shift = (up - dn) / 2;
         if (up < 0 && up > shift)
            shift = up;
         if (dn < 0 && -dn < shift)
            shift = -dn;
         for (int i = 0; i < LANES; i++)
            m[i] = m[i] + shift;
      end
      // lower bound first, then upper: min above max reads max
      for (int i = 0; i < LANES; i++) begin
         v = (m[i] < lo_lim) ? lo_lim : m[i];
         v = (v > hi) ? hi : v;
         lane[i] = v[PWM_W-1:0];
      end
      cmd.x_pos = lane[MOT_X_POS];
      cmd.x_neg = lane[MOT_X_NEG];
      cmd.y_pos = lane[MOT_Y_POS];
      cmd.y_neg = lane[MOT_Y_NEG];
      return cmd;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      err_count++;
   endtask

   task automatic check_motor(input string lane, input logic [PWM_W-1:0] got,
                              input logic [PWM_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", lane, got, want));
   endtask

   // drive result-side stall: a requested hold-off first, else random
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // check each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      motor_cmd_type want;
      if (!reset && req_valid && req_stall)
         input_stall_cycles++;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (motor_queue.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = motor_queue.pop_front();
            check_motor("motor_x_pos", rsp_motor_x_pos, want.x_pos);
            check_motor("motor_x_neg", rsp_motor_x_neg, want.x_neg);
            check_motor("motor_y_pos", rsp_motor_y_pos, want.y_pos);
            check_motor("motor_y_neg", rsp_motor_y_neg, want.y_neg);
            beats_checked++;
         end
      end
   end

   // Offer one beat, with random idle cycles ahead of it; hold until accepted.
   task automatic send_beat(input logic kind, input logic [THR_W-1:0] thr,
                            input logic signed [TILT_W-1:0] tx,
                            input logic signed [TILT_W-1:0] ty);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_kind             <= kind;
      req_throttle_percent <= thr;
      req_tilt_x           <= tx;
      req_tilt_y           <= ty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      motor_queue.push_back(mix_beat(kind, thr, tx, ty));
      beats_sent++;
   endtask

   // Drop valid and wait until every expected result beat has come back.
   task automatic wait_results_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (motor_queue.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (motor_queue.size() != 0) begin
         report_mismatch($sformatf("%0d result beats never arrived", motor_queue.size()));
         motor_queue.delete();
      end
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      // register takes the value at this edge
      case (csr_index_type'(addr[CSR_AW-1:2]))
         CSR_PWM_MAX:  pwm_max_now = data[PWM_W-1:0];
         CSR_PWM_MIN:  pwm_min_now = data[PWM_W-1:0];
         CSR_PWM_IDLE: pwm_idle_now = data[PWM_W-1:0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input csr_index_type idx, input logic [PWM_W-1:0] want);
      logic [CSR_DW-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      if (got[PWM_W-1:0] !== want)
         report_mismatch($sformatf("read of %s got %0d want %0d", idx.name(),
                                   got[PWM_W-1:0], want));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write all three limits once the pipe is empty; junk in the upper data bits.
   task automatic set_pwm(input logic [PWM_W-1:0] max_v, input logic [PWM_W-1:0] min_v,
                          input logic [PWM_W-1:0] idle_v);
      wait_results_drained();
      csr_write({CSR_PWM_MAX, 2'b00}, {16'($urandom()), max_v});
      csr_write({CSR_PWM_MIN, 2'b00}, {16'($urandom()), min_v});
      csr_write({CSR_PWM_IDLE, 2'b00}, {16'($urandom()), idle_v});
      csr_read_check(CSR_PWM_MAX, pwm_max_now);
      csr_read_check(CSR_PWM_MIN, pwm_min_now);
      csr_read_check(CSR_PWM_IDLE, pwm_idle_now);
      settings_count++;
   endtask

   function automatic logic signed [TILT_W-1:0] random_tilt();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return TILT_W'($urandom());
         default: return TILT_W'(int'($urandom_range(1200)) - 600);
      endcase
   endfunction

   task automatic send_random_beat();
      logic kind;
      logic [THR_W-1:0] thr;
      kind = 1'($urandom_range(1));
      case ($urandom_range(9))
         0:       thr = '0;
         1:       thr = THR_W'($urandom_range(127, 101));
         default: thr = THR_W'($urandom_range(100, 1));
      endcase
      send_beat(kind, thr, random_tilt(), random_tilt());
   endtask

   task automatic choose_settings(input int choice);
      logic [PWM_W-1:0] mx, mn, id;
      case (choice % 6)
         0: begin
            mx = PWM_MAX_RST; mn = PWM_MIN_RST; id = PWM_IDLE_RST;
         end
         1: begin
            mx = 16'hFFFF; mn = '0; id = '0;
         end
         2: begin
            id = PWM_W'($urandom_range(3000));
            mn = id + PWM_W'($urandom_range(1000));
            mx = mn + PWM_W'($urandom_range(4000));
         end
         3: begin
            mx = PWM_W'($urandom()); mn = PWM_W'($urandom()); id = PWM_W'($urandom());
         end
         4: begin
            // min above max
            mn = PWM_W'($urandom_range(65535, 2000));
            mx = PWM_W'($urandom_range(mn - 1));
            id = PWM_W'($urandom());
         end
         default: begin
            // narrow window: desaturation nearly always kicks in
            mn = PWM_W'($urandom_range(60000));
            mx = mn + PWM_W'($urandom_range(50));
            id = PWM_W'($urandom_range(mn));
         end
      endcase
      set_pwm(mx, mn, id);
   endtask

   task automatic test_reset_values();
      csr_read_check(CSR_PWM_MAX, PWM_MAX_RST);
      csr_read_check(CSR_PWM_MIN, PWM_MIN_RST);
      csr_read_check(CSR_PWM_IDLE, PWM_IDLE_RST);
   endtask

   // Field extremes and ignored fields under the reset limits.
   task automatic test_directed_mix();
      send_beat(1'b0, 7'd0, 16'sd0, 16'sd0);
      send_beat(1'b1, 7'd0, 16'sd100, -16'sd50);
      send_beat(1'b0, 7'd50, 16'sh5A5A, 16'shA5A5);
      send_beat(1'b0, 7'd100, 16'sd0, 16'sd0);
      send_beat(1'b0, 7'd127, 16'sd0, 16'sd0);
      send_beat(1'b1, 7'd127, 16'sh7FFF, 16'sh8000);
      send_beat(1'b1, 7'd0, 16'sh8000, 16'sh7FFF);
      send_beat(1'b0, 7'd1, 16'shFFFF, 16'shFFFF);
      send_beat(1'b1, 7'h55, 16'sd300, -16'sd300);
      send_beat(1'b0, 7'd64, 16'sd0, 16'sd0);
      send_beat(1'b0, 7'd0, 16'sh7FFF, 16'sh7FFF);
      send_beat(1'b0, 7'd100, 16'sd0, 16'sd0);
      send_beat(1'b1, 7'h2A, 16'sd400, 16'sd0);
      send_beat(1'b1, 7'd0, 16'sd0, 16'sd0);
   endtask

   // Idle outside the window, max below idle, min above max, full and empty range.
   task automatic test_odd_limits();
      set_pwm(16'd2000, 16'd1100, 16'd3000);
      send_beat(1'b0, 7'd0, 16'sd0, 16'sd0);
      send_beat(1'b0, 7'd37, 16'sd0, 16'sd0);
      send_beat(1'b1, 7'd0, 16'sd75, -16'sd20);
      set_pwm(16'd1000, 16'd3000, 16'd500);
      send_beat(1'b0, 7'd0, 16'sd0, 16'sd0);
      send_beat(1'b0, 7'd80, 16'sd0, 16'sd0);
      send_beat(1'b1, 7'd0, 16'sh8000, 16'sd5);
      set_pwm(16'hFFFF, 16'h0000, 16'h0000);
      send_beat(1'b0, 7'd127, 16'sh7FFF, 16'sh8000);
      send_beat(1'b0, 7'd3, 16'sd0, 16'sd0);
      set_pwm(16'h0000, 16'h0000, 16'hFFFF);
      send_beat(1'b0, 7'd0, 16'sd0, 16'sd0);
      send_beat(1'b0, 7'd99, 16'sd0, 16'sd0);
   endtask

   // A write to the hole at index 3 must leave all three limits alone.
   task automatic test_unmapped_register();
      wait_results_drained();
      csr_write(UNMAPPED_ADDR, $urandom());
      csr_read_check(CSR_PWM_MAX, pwm_max_now);
      csr_read_check(CSR_PWM_MIN, pwm_min_now);
      csr_read_check(CSR_PWM_IDLE, pwm_idle_now);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int first_choice);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int chunk = 0; chunk < 4; chunk++) begin
         choose_settings(first_choice + chunk);
         repeat (CHUNK_BEATS) send_random_beat();
      end
   endtask

   // Hold the result side off while beats keep coming, so the input stalls.
   task automatic test_backpressure();
      wait_results_drained();
      send_idle_pct = 0;
      recv_idle_pct = 20;
      hold_request = HOLD_CYCLES;
      repeat (30) send_random_beat();
      wait_results_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_mix();
      test_odd_limits();
      test_unmapped_register();
      test_random_traffic(29, 61, 0);
      test_backpressure();
      test_random_traffic(61, 29, 4);
      test_random_traffic(0, 0, 2);
      wait_results_drained();
      $display("covered %0d request beats, %0d result beats checked, %0d PWM limit sets",
               beats_sent, beats_checked, settings_count);
      $display("input held off by the mixer for %0d cycles", input_stall_cycles);
      if (err_count == 0)
         $display("quad_motor_mixer_desaturate_top regression: pass");
      else
         $display("quad_motor_mixer_desaturate_top regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("timeout waiting on the mixer");
      $display("quad_motor_mixer_desaturate_top regression: fail");
      $finish;
   end

endmodule
